FILE: hdl/s2l_pkg.sv
// Shared constants, types and the sRGB linearization table for the Lab converter.
`timescale 1ns / 1ps
package s2l_pkg;

    localparam int QB      = 30;   // fraction bits of internal fixed point
    localparam int LIN_W   = 31;   // linear channel width (up to 1.0)
    localparam int MAT_W   = 30;   // matrix coefficient width (x1e9)
    localparam int WHT_W   = 31;   // white point width (x1e9)
    localparam int SUM_W   = 62;   // matrix row sum plus rounding term
    localparam int T_W     = 31;   // relative XYZ width
    localparam int ROOT_W  = 31;   // cube root width
    localparam int LDIV_W  = 30;   // linear companding quotient width
    localparam int LNUM_W  = 40;   // linear companding numerator width
    localparam int LAB_W   = 44;   // signed width of unrounded L, a, b
    localparam int DIV_LAT = 3;    // stages of the constant divider

    typedef logic [LIN_W-1:0] t_lin_tab [256];
    typedef logic [MAT_W-1:0] t_mat [3][3];
    typedef logic [WHT_W-1:0] t_white [3];

    localparam t_mat MAT = '{
        '{30'd412380884, 30'd357572836, 30'd180452298},
        '{30'd212619863, 30'd715138788, 30'd72149943},
        '{30'd19343496,  30'd119212169, 30'd950506566}
    };

    localparam t_white WHITE = '{31'd950406017, 31'd999908594, 31'd1089062231};

    function automatic logic [63:0] f_pow5(input logic [63:0] r);
        logic [63:0] p;
        p = (r * r) >> QB;
        p = (p * r) >> QB;
        p = (p * r) >> QB;
        p = (p * r) >> QB;
        return p;
    endfunction

    // largest r in [0, hi] with r^5 (truncating products) not above target
    function automatic logic [63:0] f_root5(input logic [63:0] target,
                                            input logic [63:0] hi_in);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = hi_in;
        for (int i = 0; i < 64; i++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (f_pow5(mid) <= target) lo = mid;
                else hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // inverse sRGB gamma of one 8-bit code, Q30
    function automatic logic [63:0] f_lin(input logic [63:0] c);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        if (c * 64'd1000000000 <= 64'd40449936 * 64'd255) begin
            return (((c * 64'd100) << QB) + 64'd164730) / 64'd329460;
        end
        u  = (((64'd1000 * c + 64'd14025) << QB) + 64'd134512) / 64'd269025;
        u2 = (u * u + (64'd1 << (QB - 1))) >> QB;
        r  = f_root5(u2, (64'd1 << QB) + 64'd1);
        return (u2 * r + (64'd1 << (QB - 1))) >> QB;
    endfunction

    function automatic t_lin_tab f_lin_tab();
        t_lin_tab tab;
        logic [63:0] v;
        for (int c = 0; c < 256; c++) begin
            v = f_lin(64'(c));
            tab[c] = v[LIN_W-1:0];
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = f_lin_tab();

endpackage

FILE: hdl/s2l_div.sv
// Three-stage divider by a constant: reciprocal estimate, check product, small correction.
`timescale 1ns / 1ps
module s2l_div #(
    parameter int NW = 62,
    parameter int QW = 31,
    parameter int DW = 31,
    parameter logic [DW-1:0] DIVISOR = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    output logic          o_valid,
    output logic [QW-1:0] o_quot
);
    // numerator must stay below DIVISOR * 2^QW
    // estimate never exceeds the quotient and trails it by at most four

    localparam int SW = DW - 1;          // numerator bits dropped for the estimate
    localparam int PW = 31;              // reciprocal scale
    localparam int EW = NW - SW;         // estimate operand width
    localparam int RW = DW + 3;          // remainder width
    localparam logic [63:0] RECIP = (64'd1 << (SW + PW)) / 64'(DIVISOR);
    localparam logic [RW-1:0] D1 = RW'(DIVISOR);
    localparam logic [RW-1:0] D2 = D1 << 1;
    localparam logic [RW-1:0] D3 = D1 + D2;
    localparam logic [RW-1:0] D4 = D1 << 2;

    logic [EW-1:0]    w_est_in;
    logic [QW-1:0]    w_qe;
    logic [QW+DW-1:0] w_qd_full;
    logic [RW-1:0]    w_rem;
    logic [2:0]       w_fix;
    logic [EW+31:0]   r_prod;
    logic [RW-1:0]    r_n1;
    logic [RW-1:0]    r_n2;
    logic [QW-1:0]    r_qe;
    logic [RW-1:0]    r_qd;
    logic [QW-1:0]    r_q;
    logic             r_v1, r_v2, r_v3;

    assign w_est_in  = i_num[NW-1:SW];
    assign w_qe      = r_prod[PW +: QW];
    assign w_qd_full = w_qe * DIVISOR;

    // remainder is below 5 * DIVISOR, so its low bits are exact
    always_comb begin
        w_rem = r_n2 - r_qd;
        w_fix = 3'(w_rem >= D1) + 3'(w_rem >= D2) + 3'(w_rem >= D3) + 3'(w_rem >= D4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_est_in * RECIP[31:0];
            r_n1   <= i_num[RW-1:0];
            r_qe   <= w_qe;
            r_qd   <= w_qd_full[RW-1:0];
            r_n2   <= r_n1;
            r_q    <= r_qe + QW'(w_fix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_quot  = r_q;

endmodule

FILE: hdl/s2l_cbrt.sv
// Pipelined Q30 cube root, one result bit per two stages (square, then cube and compare).
`timescale 1ns / 1ps
module s2l_cbrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [s2l_pkg::T_W-1:0]    i_t,
    output logic                       o_valid,
    output logic [s2l_pkg::ROOT_W-1:0] o_root
);
    import s2l_pkg::*;

    localparam int NB = ROOT_W;

    logic [ROOT_W-1:0] w_r_in [NB];
    logic [T_W-1:0]    w_t_in [NB];
    logic              w_v_in [NB];
    logic [ROOT_W-1:0] n_c    [NB];
    logic [2*ROOT_W-1:0] w_sq_full [NB];
    logic [ROOT_W+ROOT_W+1:0] w_cu_full [NB];
    logic [ROOT_W+1:0] w_cube [NB];
    logic [ROOT_W-1:0] n_r    [NB];

    logic [ROOT_W-1:0] r_a_c  [NB];
    logic [ROOT_W-1:0] r_a_r  [NB];
    logic [T_W-1:0]    r_a_t  [NB];
    logic [ROOT_W:0]   r_a_sq [NB];
    logic              r_a_v  [NB];
    logic [ROOT_W-1:0] r_b_r  [NB];
    logic [T_W-1:0]    r_b_t  [NB];
    logic              r_b_v  [NB];

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            if (k == 0) begin
                w_r_in[k] = '0;
                w_t_in[k] = i_t;
                w_v_in[k] = i_valid;
            end else begin
                w_r_in[k] = r_b_r[k-1];
                w_t_in[k] = r_b_t[k-1];
                w_v_in[k] = r_b_v[k-1];
            end
            n_c[k] = w_r_in[k];
            n_c[k][NB-1-k] = 1'b1;
            w_sq_full[k] = n_c[k] * n_c[k];
            // square step result feeds the cube step of the same bit
            w_cu_full[k] = r_a_sq[k] * r_a_c[k];
            w_cube[k]    = w_cu_full[k][QB +: ROOT_W+2];
            n_r[k] = (w_cube[k] <= {2'b00, r_a_t[k]}) ? r_a_c[k] : r_a_r[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_a_c[k]  <= n_c[k];
                r_a_r[k]  <= w_r_in[k];
                r_a_t[k]  <= w_t_in[k];
                r_a_sq[k] <= w_sq_full[k][QB +: ROOT_W+1];
                r_b_r[k]  <= n_r[k];
                r_b_t[k]  <= r_a_t[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NB; k++) begin
                r_a_v[k] <= 1'b0;
                r_b_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_a_v[k] <= w_v_in[k];
                r_b_v[k] <= r_a_v[k];
            end
        end
    end

    assign o_valid = r_b_v[NB-1];
    assign o_root  = r_b_r[NB-1];

endmodule

FILE: hdl/srgb_to_cielab_unit.sv
// sRGB to CIE L*a*b* converter: top level with matrix, companding select and Lab output.
// Stages from request acceptance to o_valid: 3 table/matrix stages,
//   3 white-point divider stages, 1 select stage, 62 cube root stages, 1 Lab, 1 output.
// Throughput: one request per clock while o_stall is low; 62 cube root stages set depth.
// A two-entry output buffer keeps the pipeline moving while one result waits.
// Reset (synchronous, active low) empties the pipeline and the output buffer.
`timescale 1ns / 1ps
module srgb_to_cielab_unit #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_rgb_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_lightness,
    output logic [15:0] o_green_red_axis,
    output logic [15:0] o_blue_yellow_axis
);
    import s2l_pkg::*;

    localparam int SH        = QB - FRACTION_BITS;
    localparam int LMAX      = ((100 << FRACTION_BITS) > 32767) ? 32767
                                                               : (100 << FRACTION_BITS);
    localparam int CBRT_LAT  = 2 * ROOT_W;
    localparam int LIN_LAT   = DIV_LAT;
    localparam int DL        = CBRT_LAT - LIN_LAT;

    logic w_en;            // whole pipeline advances
    logic w_push;
    logic w_pop;

    // stage 0: linearized channels
    logic [LIN_W-1:0] r_lin [3];
    logic             r_v0;
    // stage 1: matrix products
    logic [MAT_W+LIN_W-1:0] r_prod [3][3];
    logic             r_v1;
    // stage 2: row sums plus half divisor
    logic [SUM_W-1:0] r_sum [3];
    logic             r_v2;
    // divider outputs
    logic             w_div_v;
    logic [T_W-1:0]   w_t [3];
    // stage 3: companding operands
    logic [T_W-1:0]    r_t    [3];
    logic [LNUM_W-1:0] r_lnum [3];
    logic [2:0]        r_root_sel;
    logic              r_v3;
    logic [46:0]       w_lscaled [3];
    logic [46:0]       w_lnum_full [3];
    // companding outputs
    logic              w_cb_v;
    logic [ROOT_W-1:0] w_root [3];
    logic [LDIV_W-1:0] w_lq [3];
    logic [LDIV_W-1:0] r_dl_lin [3][DL];
    logic [2:0]        r_dl_sel [CBRT_LAT];
    logic [ROOT_W-1:0] w_f [3];
    // stage 4: unrounded Lab
    logic signed [LAB_W-1:0] w_fs [3];
    logic signed [LAB_W-1:0] r_lq, r_aq, r_bq;
    logic                    r_v4;
    // rounding and saturation
    logic signed [LAB_W-1:0] w_rnd [3];
    logic signed [LAB_W-1:0] w_mag, w_shr;
    logic [14:0] w_l_out;
    logic [15:0] w_a_out, w_b_out;
    // output register and skid entry
    logic        r_o_valid, r_s_valid;
    logic [14:0] r_o_l, r_s_l;
    logic [15:0] r_o_a, r_s_a, r_o_b, r_s_b;

    assign w_en    = !r_s_valid;
    assign o_stall = r_s_valid;

    // stage 0: gamma table, one read per channel
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin[0] <= LIN_TAB[i_rgb_word[23:16]];
            r_lin[1] <= LIN_TAB[i_rgb_word[15:8]];
            r_lin[2] <= LIN_TAB[i_rgb_word[7:0]];
        end
    end

    // stage 1: nine products of the XYZ matrix
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= MAT[i][j] * r_lin[j];
                end
            end
        end
    end

    // stage 2: row sums with rounding offset for the white point division
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= SUM_W'(r_prod[i][0]) + SUM_W'(r_prod[i][1])
                          + SUM_W'(r_prod[i][2]) + SUM_W'(WHITE[i] >> 1);
            end
        end
    end

    // white point division, relative XYZ in Q30
    for (genvar g = 0; g < 3; g++) begin : g_wdiv
        if (g == 0) begin : g_first
            s2l_div #(
                .NW(SUM_W), .QW(T_W), .DW(WHT_W), .DIVISOR(WHITE[g])
            ) u_div (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v2),
                .i_num(r_sum[g]), .o_valid(w_div_v), .o_quot(w_t[g])
            );
        end else begin : g_rest
            s2l_div #(
                .NW(SUM_W), .QW(T_W), .DW(WHT_W), .DIVISOR(WHITE[g])
            ) u_div (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v2),
                .i_num(r_sum[g]), .o_valid(), .o_quot(w_t[g])
            );
        end
    end

    // stage 3: branch select and numerator of the linear segment
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lscaled[i]   = 47'(w_t[i]) * 47'd24389;
            w_lnum_full[i] = w_lscaled[i] + (47'd432 << QB) + 47'd1566;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i]          <= w_t[i];
                r_lnum[i]       <= w_lnum_full[i][LNUM_W-1:0];
                r_root_sel[i]   <= (w_lscaled[i] > (47'd216 << QB));
            end
        end
    end

    // cube root for the upper segment, divide by 3132 for the linear one
    for (genvar g = 0; g < 3; g++) begin : g_comp
        if (g == 0) begin : g_first
            s2l_cbrt u_cbrt (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
                .i_t(r_t[g]), .o_valid(w_cb_v), .o_root(w_root[g])
            );
        end else begin : g_rest
            s2l_cbrt u_cbrt (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
                .i_t(r_t[g]), .o_valid(), .o_root(w_root[g])
            );
        end
        s2l_div #(
            .NW(LNUM_W), .QW(LDIV_W), .DW(12), .DIVISOR(12'd3132)
        ) u_ldiv (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_v3),
            .i_num(r_lnum[g]), .o_valid(), .o_quot(w_lq[g])
        );
    end

    // align linear quotient and branch select with the cube root
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dl_lin[i][0] <= w_lq[i];
                for (int k = 1; k < DL; k++) r_dl_lin[i][k] <= r_dl_lin[i][k-1];
            end
            r_dl_sel[0] <= r_root_sel;
            for (int k = 1; k < CBRT_LAT; k++) r_dl_sel[k] <= r_dl_sel[k-1];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_f[i]  = r_dl_sel[CBRT_LAT-1][i] ? w_root[i]
                                               : ROOT_W'(r_dl_lin[i][DL-1]);
            w_fs[i] = $signed(LAB_W'(w_f[i]));
        end
    end

    // stage 4: L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lq <= w_fs[1] * 44'sd116 - (44'sd16 <<< QB);
            r_aq <= (w_fs[0] - w_fs[1]) * 44'sd500;
            r_bq <= (w_fs[1] - w_fs[2]) * 44'sd200;
        end
    end

    // round to nearest, ties away from zero, then saturate
    function automatic logic signed [LAB_W-1:0] f_round(input logic signed [LAB_W-1:0] v);
        logic signed [LAB_W-1:0] mag;
        logic signed [LAB_W-1:0] q;
        mag = (v < 0) ? -v : v;
        q   = (mag + (44'sd1 <<< (SH - 1))) >>> SH;
        return (v < 0) ? -q : q;
    endfunction

    always_comb begin
        w_rnd[0] = f_round(r_lq);
        w_rnd[1] = f_round(r_aq);
        w_rnd[2] = f_round(r_bq);
        w_mag    = w_rnd[0];
        w_shr    = w_rnd[1];
        if (w_mag < 0)                        w_l_out = '0;
        else if (w_mag > LAB_W'(LMAX))        w_l_out = 15'(LMAX);
        else                                  w_l_out = w_mag[14:0];
        if (w_shr < -44'sd32768)              w_a_out = 16'h8000;
        else if (w_shr > 44'sd32767)          w_a_out = 16'h7fff;
        else                                  w_a_out = w_shr[15:0];
        if (w_rnd[2] < -44'sd32768)           w_b_out = 16'h8000;
        else if (w_rnd[2] > 44'sd32767)       w_b_out = 16'h7fff;
        else                                  w_b_out = w_rnd[2][15:0];
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= w_div_v;
            r_v4 <= w_cb_v;
        end
    end

    // output register plus one skid entry
    assign w_pop  = r_o_valid && !i_stall;
    assign w_push = w_en && r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (w_pop) begin
                r_s_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_o_valid || w_pop) r_o_valid <= 1'b1;
            else                     r_s_valid <= 1'b1;
        end else if (w_pop) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (w_pop) begin
                r_o_l <= r_s_l;
                r_o_a <= r_s_a;
                r_o_b <= r_s_b;
            end
        end else if (w_push) begin
            if (!r_o_valid || w_pop) begin
                r_o_l <= w_l_out;
                r_o_a <= w_a_out;
                r_o_b <= w_b_out;
            end else begin
                r_s_l <= w_l_out;
                r_s_a <= w_a_out;
                r_s_b <= w_b_out;
            end
        end
    end

    assign o_valid            = r_o_valid;
    assign o_lightness        = r_o_l;
    assign o_green_red_axis   = r_o_a;
    assign o_blue_yellow_axis = r_o_b;

    // skid entry is only occupied behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid) else $error("skid full with empty output");

    // skid fills only when the output was held by a stall
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s_valid) |-> $past(r_o_valid && i_stall))
        else $error("skid filled without stall");

    // lightness never leaves its range
    a_l_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_l <= 15'(LMAX))) else $error("lightness out of range");

    // a drained output with nothing behind it goes empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !r_s_valid && !r_v4) |=> !r_o_valid)
        else $error("stale result kept");

endmodule

FILE: tb/sv/srgb_to_cielab_unit_tb.sv
// Testbench for the sRGB to CIE L*a*b* converter: random and corner pixels, scoreboard check.
`timescale 1ns / 1ps
module srgb_to_cielab_unit_tb;

    localparam int FRAC      = 8;
    localparam int QF        = 30;
    localparam int N_RANDOM  = 400;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] in_rgb;
    logic        out_valid;
    logic        out_stall;
    logic [14:0] out_l;
    logic [15:0] out_a;
    logic [15:0] out_b;

    int          fail_cnt;
    int          req_cnt;
    int          res_cnt;
    int          idle_cyc;
    bit          quiet;     // last part of the run: no idling on either side

    srgb_to_cielab_unit #(.FRACTION_BITS(FRAC)) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_stall            (in_stall),
        .i_rgb_word         (in_rgb),
        .o_valid            (out_valid),
        .i_stall            (out_stall),
        .o_lightness        (out_l),
        .o_green_red_axis   (out_a),
        .o_blue_yellow_axis (out_b)
    );

    typedef struct packed {
        logic [14:0] l;
        logic [15:0] a;
        logic [15:0] b;
    } lab_t;

    // ---- Lab predictor (64-bit unsigned fixed point, 30 fraction bits) ----
    function automatic logic [63:0] qmul30(logic [63:0] x, logic [63:0] y);
        return (x * y) >> QF;
    endfunction

    // largest r <= top whose 3rd/5th power (truncating products) stays <= goal
    function automatic logic [63:0] int_root(logic [63:0] goal, logic [63:0] top,
                                             bit fifth);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        lo = 0;
        hi = top;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            p = qmul30(qmul30(mid, mid), mid);
            if (fifth) p = qmul30(qmul30(p, mid), mid);
            if (p <= goal) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [63:0] degamma(logic [63:0] c);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] r;
        if (c * 64'd1000000000 <= 64'd40449936 * 64'd255)
            return (((c * 64'd100) << QF) + 64'd164730) / 64'd329460;
        u  = (((64'd1000 * c + 64'd14025) << QF) + 64'd134512) / 64'd269025;
        u2 = (u * u + (64'd1 << (QF - 1))) >> QF;
        r  = int_root(u2, (64'd1 << QF) + 1, 1'b1);   // u^2.4 = u^2 * u^0.4
        return (u2 * r + (64'd1 << (QF - 1))) >> QF;
    endfunction

    function automatic logic [63:0] lab_curve(logic [63:0] t);
        if (t * 64'd24389 > (64'd216 << QF))
            return int_root(t, 64'd1 << (QF + 1), 1'b0);
        return (64'd24389 * t + (64'd432 << QF) + 64'd1566) / 64'd3132;
    endfunction

    function automatic longint round_to_out(longint v);
        longint half;
        half = longint'(1) <<< (QF - FRAC - 1);
        if (v >= 0) return (v + half) >>> (QF - FRAC);
        return -(((-v) + half) >>> (QF - FRAC));
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic lab_t predict_lab(logic [23:0] rgb);
        logic [63:0] lin [3];
        logic [63:0] sum;
        longint      f [3];
        longint      lq, aq, bq, lmax;
        lab_t        res;
        lin[0] = degamma(64'(rgb[23:16]));
        lin[1] = degamma(64'(rgb[15:8]));
        lin[2] = degamma(64'(rgb[7:0]));
        for (int i = 0; i < 3; i++) begin
            sum = 64'(s2l_pkg::MAT[i][0]) * lin[0] + 64'(s2l_pkg::MAT[i][1]) * lin[1]
                + 64'(s2l_pkg::MAT[i][2]) * lin[2];
            f[i] = longint'(lab_curve((sum + 64'(s2l_pkg::WHITE[i] >> 1))
                                      / 64'(s2l_pkg::WHITE[i])));
        end
        lq = 116 * f[1] - (longint'(16) <<< QF);
        aq = 500 * (f[0] - f[1]);
        bq = 200 * (f[1] - f[2]);
        lmax = longint'(100) <<< FRAC;
        if (lmax > 32767) lmax = 32767;
        res.l = 15'(sat(round_to_out(lq), 0, lmax));
        res.a = 16'(sat(round_to_out(aq), -32768, 32767));
        res.b = 16'(sat(round_to_out(bq), -32768, 32767));
        return res;
    endfunction

    // ---- scoreboard ----
    class lab_scoreboard;
        lab_t pending[$];
        int   errors;

        function void note_pixel(logic [23:0] rgb);
            pending.push_back(predict_lab(rgb));
        endfunction

        function void check_lab(lab_t got);
            lab_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result L=%0d a=%0d b=%0d", $time,
                         got.l, $signed(got.a), $signed(got.b));
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.l !== want.l) begin
                $display("%0t: lightness expected %0d actual %0d", $time, want.l, got.l);
                errors++;
            end
            if (got.a !== want.a) begin
                $display("%0t: green_red_axis expected %0d actual %0d", $time,
                         $signed(want.a), $signed(got.a));
                errors++;
            end
            if (got.b !== want.b) begin
                $display("%0t: blue_yellow_axis expected %0d actual %0d", $time,
                         $signed(want.b), $signed(got.b));
                errors++;
            end
        endfunction
    endclass

    lab_scoreboard sb;

    // 4 ns clock
    always begin
        clk = 1'b1; #2;
        clk = 1'b0; #2;
    end

    // Sample both handshakes at the rising edge; the watchdog counts idle cycles.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.note_pixel(in_rgb);
                req_cnt++;
            end
            if (out_valid && !out_stall) begin
                sb.check_lab('{out_l, out_a, out_b});
                res_cnt++;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= WDOG_MAX) begin
                $display("Watchdog: no traffic for %0d cycles", WDOG_MAX);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: stalls in random bursts, dropped at the end.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Present one request and hold it until accepted; optional gap first.
    task automatic send_pixel(logic [23:0] rgb);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_rgb   = rgb;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_chan();
        // bias toward the dark segment, the knee near code 10/11 and the bright end
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 12));
            1: return 8'($urandom_range(243, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [23:0] corner [$];
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_rgb   = '0;
        quiet    = 1'b0;
        req_cnt  = 0;
        res_cnt  = 0;
        idle_cyc = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // black, white, primaries, secondaries, gamma knee, grays, alternating bits
        corner = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                   24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0A0A0A, 24'h0B0B0B,
                   24'h0A0B0A, 24'h010101, 24'h808080, 24'hFEFEFE, 24'hAAAAAA,
                   24'h555555, 24'h000001, 24'h010000, 24'h000100, 24'h0000FE,
                   24'hFF00FE, 24'h00FF01};
        foreach (corner[i]) send_pixel(corner[i]);

        // sender holds off until the pipe is empty
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM * 3 / 4) quiet = 1'b1;
            if ($urandom_range(0, 1)) send_pixel(24'($urandom()));
            else send_pixel({rand_chan(), rand_chan(), rand_chan()});
        end
        wait_drained();
        repeat (DRAIN_CYC) @(negedge clk);

        $display("Converted %0d pixels (corners, primaries, gamma knee, random) with",
                 req_cnt);
        $display("random stalls on both sides; %0d results checked.", res_cnt);
        fail_cnt = sb.errors + sb.pending.size();
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
